// ===== hdl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg : shared types and codes for the slip style frame decoder
// byte codes, result kinds and the per-beat decision record
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] CODE_DC3     = 8'h0D;
  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_END_ESC = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;
  localparam logic [7:0] CODE_DC3_ESC = 8'hDE;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_FRAME    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] position;
    logic        esc_nxt;
    logic [15:0] count_nxt;
  } step_t;

endpackage

// ===== hdl/slip_style_frame_decoder_core.sv =====
// One received byte is taken per beat, and a byte can enter in every cycle unless a
// stalled result holds the input. The decision for a byte is made in the cycle it
// is accepted; its result, if any, sits in the output register from the next
// cycle until taken, and a new byte is accepted while that register is empty or
// being drained in the same cycle. Byte 0x0D, in or out of an escape, and ESC
// outside an escape give no result unless the stored count has reached the buffer
// limit, in which case every byte reports overflow. The buffer capacity register may
// be written only while the block is idle.
// ----------------------------------------------------------------------------
// slip_style_frame_decoder_core : slip style receive deframer
// escape decoding, frame length report and buffer overflow detection
// ----------------------------------------------------------------------------
module slip_style_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_buffer_capacity
);
  import sfd_pkg::*;

  logic        esc_r;
  logic [15:0] count_r;
  logic [15:0] capacity_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  kind_t       kind_r;
  logic [7:0]  data_r;
  logic [15:0] pos_r;
  logic        in_fire;
  step_t       step;

  sfd_step u_step (
    .rx_byte  (in_rx_byte),
    .esc      (esc_r),
    .count    (count_r),
    .capacity (capacity_r),
    .step     (step)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire && step.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r       <= 1'b0;
      count_r     <= 16'd0;
      capacity_r  <= CAPACITY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        capacity_r <= cfg_buffer_capacity;
      end
      if (in_fire) begin
        esc_r   <= step.esc_nxt;
        count_r <= step.count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire && step.emit) begin
      kind_r <= step.kind;
      data_r <= step.data_byte;
      pos_r  <= step.position;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_data_byte   = data_r;
  assign out_position    = pos_r;

  a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step.kind == KIND_OVERFLOW && step.emit) |=> (count_r == 16'd0 && !esc_r))
    else $error("overflow did not clear decoder state");

  a_data_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step.emit && step.kind == KIND_DATA)
      |=> (count_r == $past(count_r) + 16'd1))
    else $error("data beat did not advance the count");

  a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_OVERFLOW) |-> (pos_r == 16'd0 && data_r == 8'd0))
    else $error("overflow result carries non-zero fields");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result is stalled");

  a_frame_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step.emit && step.kind == KIND_FRAME) |=> (count_r == 16'd0))
    else $error("frame close did not reset the count");

endmodule

// ===== hdl/sfd_step.sv =====
// ----------------------------------------------------------------------------
// sfd_step : per-beat deframing decision
// overflow check, escape decoding, frame close and next decoder state
// ----------------------------------------------------------------------------
module sfd_step (
  input  logic          [7:0]  rx_byte,
  input  logic                 esc,
  input  logic          [15:0] count,
  input  logic          [15:0] capacity,
  output sfd_pkg::step_t       step
);
  import sfd_pkg::*;

  logic [15:0] limit;
  logic [7:0]  decoded;

  assign limit = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;

  always_comb begin
    case (rx_byte)
      CODE_END_ESC: decoded = CODE_END;
      CODE_ESC_ESC: decoded = CODE_ESC;
      CODE_DC3_ESC: decoded = CODE_DC3;
      default:      decoded = rx_byte;
    endcase
  end

  always_comb begin
    step.emit      = 1'b0;
    step.kind      = KIND_DATA;
    step.data_byte = 8'd0;
    step.position  = 16'd0;
    step.esc_nxt   = esc;
    step.count_nxt = count;
    if (count >= limit) begin
      step.emit      = 1'b1;
      step.kind      = KIND_OVERFLOW;
      step.esc_nxt   = 1'b0;
      step.count_nxt = 16'd0;
    end else if (rx_byte == CODE_DC3) begin
      // dropped, escape state kept
    end else if (esc) begin
      step.emit      = 1'b1;
      step.data_byte = decoded;
      step.position  = count;
      step.esc_nxt   = 1'b0;
      step.count_nxt = count + 16'd1;
    end else if (rx_byte == CODE_ESC) begin
      step.esc_nxt = 1'b1;
    end else if (rx_byte == CODE_END) begin
      step.emit      = 1'b1;
      step.kind      = KIND_FRAME;
      step.position  = count;
      step.count_nxt = 16'd0;
    end else begin
      step.emit      = 1'b1;
      step.data_byte = rx_byte;
      step.position  = count;
      step.count_nxt = count + 16'd1;
    end
  end

endmodule
